/* rtl/storage_voltage_monitor_charge_toggler_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the monitor RTL.
// ----------------------------------------------------------------------------
`ifndef STORAGE_VOLTAGE_MONITOR_CHARGE_TOGGLER_ASSERT_SVH
`define STORAGE_VOLTAGE_MONITOR_CHARGE_TOGGLER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted.
`define SVMCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that also holds during reset.
`define SVMCT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SVMCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SVMCT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/svmct_pkg.sv */
// ----------------------------------------------------------------------------
// svmct_pkg
// Types and constants for the storage voltage monitor and charge toggler.
// ----------------------------------------------------------------------------
`default_nettype none

package svmct_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CfgLowSet    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLowClear  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCritSet   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCritClear = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSrcEnable = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTogPeriod = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgManual    = 3'd6;

  localparam logic [31:0] SamplePeriodS = 32'd5;
  localparam logic [31:0] ToggleOffS    = 32'd1;

  localparam logic [15:0] SrcEnableRst = 16'd16000;
  localparam logic [16:0] TogPeriodRst = 17'd3600;

  localparam logic ReqTick   = 1'b0;
  localparam logic ReqReport = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [31:0]        uptime_s;
    logic [15:0]        storage_mv;
    logic [15:0]        source_mv;
    logic signed [23:0] charge_ua;
  } in_t;

  typedef struct packed {
    logic               low_voltage_flag;
    logic               critical_voltage_flag;
    logic               sample_taken;
    logic               charge_cmd_valid;
    logic               charge_on;
    logic signed [23:0] peak_current_ua;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/svmct_if.sv */
// ----------------------------------------------------------------------------
// svmct channel interfaces
// Valid/ready channels for tick/report items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface svmct_in_if;
  logic            valid;
  logic            ready;
  svmct_pkg::in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface svmct_out_if;
  logic            valid;
  logic            ready;
  svmct_pkg::out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface svmct_cfg_if;
  logic            valid;
  logic            ready;
  svmct_pkg::cfg_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/storage_voltage_monitor_charge_toggler.sv */
// ----------------------------------------------------------------------------
// storage_voltage_monitor_charge_toggler
// Hysteresis voltage flags, peak current tracking and periodic charge toggle.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   takes one item per handshake: a tick (uptime plus readings) or a
//           peak current report. Every item produces exactly one result.
//   out_ch  delivers results in item order from a single output register.
//   cfg_ch  writes one register per handshake; it is always ready. Write
//           only while no item is in flight.
// The result is registered: it appears the cycle after its item is taken.
// Throughput is one item per cycle while out_ch is not stalled; all state
// updates in the accept cycle through a chain of compares and 32-bit adds.
// When the receiver stalls, the result register holds and in_ch.ready drops
// until the result is taken; ready returns in the same cycle the result
// leaves, so the stream keeps moving without a bubble.
// Reset clears all monitor state and loads the register defaults
// (source enable 16000 mV, toggle period 3600 s, automatic mode).
// ----------------------------------------------------------------------------
`default_nettype none

`include "storage_voltage_monitor_charge_toggler_assert.svh"

module storage_voltage_monitor_charge_toggler (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  svmct_in_if.sink   in_ch,
  svmct_out_if.source out_ch,
  svmct_cfg_if.sink  cfg_ch
);

  // configuration registers
  logic [15:0] low_set_q, low_clr_q, crit_set_q, crit_clr_q, src_en_q;
  logic [16:0] tog_period_q;
  logic        manual_q;

  // monitor state
  logic [31:0]        next_sample_q, next_sample_d;
  logic [15:0]        lat_src_q, lat_src_d;
  logic signed [23:0] peak_q, peak_d;
  logic               low_q, low_d, crit_q, crit_d;
  logic [31:0]        tog_start_q, tog_start_d;
  logic [31:0]        tog_next_q, tog_next_d;
  logic               charge_q, charge_d;

  // result register
  logic            out_valid_q;
  svmct_pkg::out_t out_q, out_d;

  logic in_accept, cfg_accept;
  logic signed [23:0] charge_s, peak_cand, peak_out;
  logic is_tick, sample_due, tog_due, en_due, cmd_valid;

  assign in_ch.ready  = !out_valid_q || out_ch.ready;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_accept   = cfg_ch.valid;

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

  always_comb begin
    charge_s   = in_ch.payload.charge_ua;
    is_tick    = (in_ch.payload.req_type == svmct_pkg::ReqTick);
    peak_cand  = (charge_s > peak_q) ? charge_s : peak_q;
    sample_due = (in_ch.payload.uptime_s >= next_sample_q);

    next_sample_d = next_sample_q;
    lat_src_d     = lat_src_q;
    peak_d        = peak_q;
    low_d         = low_q;
    crit_d        = crit_q;
    tog_start_d   = tog_start_q;
    tog_next_d    = tog_next_q;
    charge_d      = charge_q;
    peak_out      = '0;
    tog_due       = 1'b0;
    en_due        = 1'b0;

    if (!is_tick) begin
      peak_out = peak_cand;
      peak_d   = '0;
    end else begin
      if (sample_due) begin
        next_sample_d = in_ch.payload.uptime_s + svmct_pkg::SamplePeriodS;
        peak_d        = peak_cand;
        lat_src_d     = in_ch.payload.source_mv;
        // set test first, clear test second: clear wins on inverted pairs
        if (in_ch.payload.storage_mv < low_set_q)  low_d  = 1'b1;
        if (in_ch.payload.storage_mv > low_clr_q)  low_d  = 1'b0;
        if (in_ch.payload.storage_mv < crit_set_q) crit_d = 1'b1;
        if (in_ch.payload.storage_mv > crit_clr_q) crit_d = 1'b0;
      end
      if (!manual_q) begin
        tog_due = (in_ch.payload.uptime_s >= tog_next_q);
        if (tog_due) begin
          tog_start_d = in_ch.payload.uptime_s;
          tog_next_d  = in_ch.payload.uptime_s + {15'd0, tog_period_q};
          charge_d    = 1'b0;
        end
        // enable decision comes last and overrides the forced off
        en_due = (in_ch.payload.uptime_s >= (tog_start_d + svmct_pkg::ToggleOffS));
        if (en_due) begin
          charge_d = (lat_src_d >= src_en_q);
        end
      end
    end
    cmd_valid = tog_due || en_due;

    out_d.low_voltage_flag      = low_d;
    out_d.critical_voltage_flag = crit_d;
    out_d.sample_taken          = is_tick && sample_due;
    out_d.charge_cmd_valid      = cmd_valid;
    out_d.charge_on             = charge_d;
    out_d.peak_current_ua       = peak_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_sample_q <= '0;
      lat_src_q     <= '0;
      peak_q        <= '0;
      low_q         <= 1'b0;
      crit_q        <= 1'b0;
      tog_start_q   <= '0;
      tog_next_q    <= '0;
      charge_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        next_sample_q <= next_sample_d;
        lat_src_q     <= lat_src_d;
        peak_q        <= peak_d;
        low_q         <= low_d;
        crit_q        <= crit_d;
        tog_start_q   <= tog_start_d;
        tog_next_q    <= tog_next_d;
        charge_q      <= charge_d;
        out_valid_q   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_set_q    <= '0;
      low_clr_q    <= '0;
      crit_set_q   <= '0;
      crit_clr_q   <= '0;
      src_en_q     <= svmct_pkg::SrcEnableRst;
      tog_period_q <= svmct_pkg::TogPeriodRst;
      manual_q     <= 1'b0;
    end else if (cfg_accept) begin
      case (cfg_ch.payload.index)
        svmct_pkg::CfgLowSet:    low_set_q    <= cfg_ch.payload.data[15:0];
        svmct_pkg::CfgLowClear:  low_clr_q    <= cfg_ch.payload.data[15:0];
        svmct_pkg::CfgCritSet:   crit_set_q   <= cfg_ch.payload.data[15:0];
        svmct_pkg::CfgCritClear: crit_clr_q   <= cfg_ch.payload.data[15:0];
        svmct_pkg::CfgSrcEnable: src_en_q     <= cfg_ch.payload.data[15:0];
        svmct_pkg::CfgTogPeriod: tog_period_q <= cfg_ch.payload.data;
        svmct_pkg::CfgManual:    manual_q     <= cfg_ch.payload.data[0];
        default: ;
      endcase
    end
  end

  `SVMCT_ASSERT(a_report_peak_cleared, clk_i, rst_ni,
    in_accept && (in_ch.payload.req_type == svmct_pkg::ReqReport) |=> (peak_q == '0),
    "peak not cleared after report item")
  `SVMCT_ASSERT(a_manual_no_cmd, clk_i, rst_ni,
    in_accept && manual_q |=> out_valid_q && !out_q.charge_cmd_valid,
    "charge command issued in manual mode")
  `SVMCT_ASSERT(a_sample_schedule, clk_i, rst_ni,
    in_accept && out_d.sample_taken |=>
      (next_sample_q == ($past(in_ch.payload.uptime_s) + svmct_pkg::SamplePeriodS)),
    "next sample time not scheduled after sample")
  `SVMCT_ASSERT(a_flags_match_state, clk_i, rst_ni,
    out_valid_q |-> (out_q.low_voltage_flag == low_q) &&
                    (out_q.critical_voltage_flag == crit_q) &&
                    (out_q.charge_on == charge_q),
    "result flags differ from monitor state")
  `SVMCT_ASSERT(a_peak_only_on_report, clk_i, rst_ni,
    out_valid_q && (out_q.peak_current_ua != '0) |->
      !out_q.sample_taken && !out_q.charge_cmd_valid,
    "tick result carries a peak value")

endmodule

`default_nettype wire
